/* rtl/core/dci_pkg.sv */
// shared types and constants for the distance crossing interpolator
// no dependencies; imported by dci_ctrl, dci_datapath and the top level
package dci_pkg;

    // field widths
    localparam int DIST_W  = 32;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 24;

    // default number of fractional bits in the fixed point format
    localparam int FRAC_BITS_DEFAULT = 8;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_TARGET = 1'b0;

    // what a result carries
    typedef enum logic [1:0] {
        EMIT_MISS   = 2'd0,
        EMIT_LOWER  = 2'd1,
        EMIT_INTERP = 2'd2
    } emit_kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       eval;
        logic       save_lower;
        logic       clear_run;
        logic       set_hit;
        logic       prep;
        logic       sel_speed;
        logic       mul;
        logic       div_load;
        logic       div_step;
        logic       finish;
        logic       emit;
        emit_kind_t kind;
    } dci_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit_done;
        logic below;
        logic last;
        logic small_gap;
        logic div_done;
        logic out_free;
    } dci_sts_t;

endpackage

/* rtl/core/dci_ctrl.sv */
// sequencer for the distance crossing interpolator
// depends on dci_pkg; drives dci_datapath through dci_cmd_t / dci_sts_t
module dci_ctrl
    import dci_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dci_sts_t sts,
    output dci_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PREP,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_FIN,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       phase_reg, phase_next;
    emit_kind_t kind_reg, kind_next;

    // state and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            kind_reg  <= EMIT_MISS;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        cmd.sel_speed = phase_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.hit_done)
                begin
                    // records after a hit are dropped, the last one ends the run
                    cmd.clear_run = sts.last;
                    state_next    = S_IDLE;
                end
                else if (sts.below)
                begin
                    if (sts.last)
                    begin
                        kind_next  = EMIT_MISS;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.save_lower = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.small_gap)
                begin
                    kind_next  = EMIT_LOWER;
                    state_next = S_EMIT;
                end
                else
                begin
                    kind_next  = EMIT_INTERP;
                    phase_next = 1'b0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                if (phase_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_EMIT:
            begin
                // wait for the output register to free up
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.clear_run = sts.last;
                    cmd.set_hit   = !sts.last;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/dci_datapath.sv */
// record registers, lower record, multiplier, shared restoring divider, output register
// depends on dci_pkg; sequenced by dci_ctrl
module dci_datapath
    import dci_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dci_cmd_t           cmd,
    output dci_sts_t           sts,
    input  logic [DIST_W-1:0]  target,
    input  logic [DIST_W-1:0]  rec_distance,
    input  logic [TIME_W-1:0]  rec_time,
    input  logic [SPEED_W-1:0] rec_speed,
    input  logic               last_record,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               reached,
    output logic [TIME_W-1:0]  time_at_target,
    output logic [SPEED_W-1:0] speed_at_target
);

    localparam int PROD_W  = 2 * DIST_W;
    localparam int DIV_BITS = PROD_W + 1;
    localparam int CNT_W   = $clog2(DIV_BITS);
    localparam int REM_W   = DIST_W + 1;
    // gap*2 below one unit means the gap is under half a unit
    localparam logic [DIST_W:0] GAP2_LIMIT = (DIST_W + 1)'(1) << FRAC_BITS;

    // captured record
    logic [DIST_W-1:0]  rec_d_reg;
    logic [TIME_W-1:0]  rec_t_reg;
    logic [SPEED_W-1:0] rec_s_reg;
    logic               rec_last_reg;

    // run state
    logic [DIST_W-1:0]  lower_d_reg;
    logic [TIME_W-1:0]  lower_t_reg;
    logic [SPEED_W-1:0] lower_s_reg;
    logic               hit_done_reg;

    // interpolation operands
    logic [DIST_W-1:0]  gap_reg, num_reg;
    logic [TIME_W-1:0]  lo_reg, mag_reg;
    logic               up_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIV_BITS-1:0] dq_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]  res_t_reg;
    logic [SPEED_W-1:0] res_s_reg;

    // output register
    logic               out_valid_reg;
    logic               reached_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SPEED_W-1:0] speed_reg;

    // combinational helpers
    logic [DIST_W-1:0]  gap_next, num_raw, num_next;
    logic [TIME_W-1:0]  lo_next, hi_next, mag_next;
    logic [PROD_W-1:0]  prod_next;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W:0]     trial;
    logic [TIME_W-1:0]  q_clamp, res_next;

    // bracket gap and clamped numerator
    always_comb
    begin
        gap_next = (rec_d_reg >= lower_d_reg) ? (rec_d_reg - lower_d_reg) : '0;
        num_raw  = (target >= lower_d_reg) ? (target - lower_d_reg) : '0;
        num_next = (num_raw > gap_next) ? gap_next : num_raw;
    end

    // pick time or speed and take the signed difference apart
    always_comb
    begin
        if (cmd.sel_speed)
        begin
            lo_next = TIME_W'(lower_s_reg);
            hi_next = TIME_W'(rec_s_reg);
        end
        else
        begin
            lo_next = lower_t_reg;
            hi_next = rec_t_reg;
        end
        mag_next = (hi_next >= lo_next) ? (hi_next - lo_next) : (lo_next - hi_next);
    end

    assign prod_next = mag_reg * num_reg;

    // one restoring division step
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], dq_reg[DIV_BITS-1]};
        trial     = {1'b0, rem_shift} - (REM_W + 1)'(gap_reg);
    end

    // clamp the quotient and apply it to the lower value
    always_comb
    begin
        if (dq_reg > DIV_BITS'(mag_reg))
        begin
            q_clamp = mag_reg;
        end
        else
        begin
            q_clamp = dq_reg[TIME_W-1:0];
        end
        res_next = up_reg ? (lo_reg + q_clamp) : (lo_reg - q_clamp);
    end

    // record capture and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rec_d_reg    <= rec_distance;
            rec_t_reg    <= rec_time;
            rec_s_reg    <= rec_speed;
            rec_last_reg <= last_record;
        end
        if (cmd.eval)
        begin
            gap_reg <= gap_next;
            num_reg <= num_next;
        end
        if (cmd.prep)
        begin
            lo_reg  <= lo_next;
            mag_reg <= mag_next;
            up_reg  <= (hi_next >= lo_next);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            dq_reg  <= DIV_BITS'(prod_reg) + DIV_BITS'(gap_reg >> 1);
            cnt_reg <= CNT_W'(DIV_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            if (!trial[REM_W])
            begin
                rem_reg <= trial[REM_W-1:0];
                dq_reg  <= {dq_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                dq_reg  <= {dq_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.finish)
        begin
            if (cmd.sel_speed)
            begin
                res_s_reg <= res_next[SPEED_W-1:0];
            end
            else
            begin
                res_t_reg <= res_next;
            end
        end
    end

    // lower record and hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_d_reg  <= '0;
            lower_t_reg  <= '0;
            lower_s_reg  <= '0;
            hit_done_reg <= 1'b0;
        end
        else if (cmd.clear_run)
        begin
            lower_d_reg  <= '0;
            lower_t_reg  <= '0;
            lower_s_reg  <= '0;
            hit_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.save_lower)
            begin
                lower_d_reg <= rec_d_reg;
                lower_t_reg <= rec_t_reg;
                lower_s_reg <= rec_s_reg;
            end
            if (cmd.set_hit)
            begin
                hit_done_reg <= 1'b1;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.kind)
                EMIT_LOWER:
                begin
                    reached_reg <= 1'b1;
                    time_reg    <= lower_t_reg;
                    speed_reg   <= lower_s_reg;
                end
                EMIT_INTERP:
                begin
                    reached_reg <= 1'b1;
                    time_reg    <= res_t_reg;
                    speed_reg   <= res_s_reg;
                end
                default:
                begin
                    reached_reg <= 1'b0;
                    time_reg    <= '0;
                    speed_reg   <= '0;
                end
            endcase
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.hit_done  = hit_done_reg;
        sts.below     = (rec_d_reg < target);
        sts.last      = rec_last_reg;
        sts.small_gap = ({gap_next, 1'b0} < GAP2_LIMIT);
        sts.div_done  = (cnt_reg == '0);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign reached         = reached_reg;
    assign time_at_target  = time_reg;
    assign speed_at_target = speed_reg;

endmodule

/* rtl/core/distance_crossing_interpolator.sv */
// distance crossing interpolator top level: config register, controller, datapath
// depends on dci_pkg, dci_ctrl and dci_datapath
//
// records (rec_distance, rec_time, rec_speed, last_record) arrive on a valid/ready
// input channel in nondecreasing distance order; target_distance is set through
// the apb port at byte address 0 and may be read back there.
// results (reached, time_at_target, speed_at_target) leave on a valid/ready
// output channel, at most one per run.
// a record that produces no result, or a miss/near-gap hit, is accepted and then
// evaluated; on a result the output register is then loaded.
// an interpolated hit sends the time and speed values each through one 32x32
// multiply and a 65-step restoring divider, one bit a cycle, shared between
// the two.
// a finished result sits in the output register while the next record is
// accepted; a second result waits in the controller until the receiver takes
// the first, and input is held off meanwhile.
// reset clears the target, the lower record and the hit flag; no output pending.
module distance_crossing_interpolator
    import dci_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DIST_W-1:0]  rec_distance,
    input  logic [TIME_W-1:0]  rec_time,
    input  logic [SPEED_W-1:0] rec_speed,
    input  logic               last_record,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               reached,
    output logic [TIME_W-1:0]  time_at_target,
    output logic [SPEED_W-1:0] speed_at_target
);

    logic [DIST_W-1:0] target_reg;
    logic              reg_sel;
    dci_cmd_t          cmd;
    dci_sts_t          sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1];

    // target register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (reg_sel == REG_TARGET))
        begin
            target_reg <= pwdata;
        end
    end

    // register read
    always_comb
    begin
        unique case (reg_sel)
            REG_TARGET: prdata = target_reg;
            default:    prdata = '0;
        endcase
    end

    dci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dci_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .target          (target_reg),
        .rec_distance    (rec_distance),
        .rec_time        (rec_time),
        .rec_speed       (rec_speed),
        .last_record     (last_record),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .reached         (reached),
        .time_at_target  (time_at_target),
        .speed_at_target (speed_at_target)
    );

`ifndef NO_ASSERTIONS
    // input is not ready in the cycle after a transfer, while the record is evaluated
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted back to back");

    // a new result is only produced while the input side is busy
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result produced while idle");

    // a miss carries zero values
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reached) |-> (time_at_target == '0 && speed_at_target == '0))
        else $error("miss result with nonzero values");
`endif

endmodule

/* bench/testbench.sv */
// self-checking testbench for distance_crossing_interpolator
// depends on dci_pkg and the distance_crossing_interpolator rtl; reads no files
// directed table of record runs, then random runs checked against a built-in predictor
module testbench
    import dci_pkg::*;
();

    localparam int RANDOM_ITEMS  = 1300;
    localparam int IDLE_WAIT     = 200;   // long enough for an interpolated hit to finish
    localparam int STALL_LIMIT   = 4000;  // cycles with no transfer before giving up
    localparam int PRESSURE_HOLD = 400;
    localparam logic [ADDR_W-1:0] TARGET_ADDR = {REG_TARGET, 2'b00};

    // one result as it leaves the block
    typedef struct packed {
        logic               reached;
        logic [TIME_W-1:0]  at_time;
        logic [SPEED_W-1:0] at_speed;
    } crossing_t;

    // one row of the directed table
    typedef struct {
        bit                 set_tgt;
        logic [DIST_W-1:0]  tgt;
        logic [DIST_W-1:0]  distance;
        logic [TIME_W-1:0]  tm;
        logic [SPEED_W-1:0] spd;
        bit                 last;
        bit                 typed;
        bit                 emits;
        crossing_t          res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [DIST_W-1:0]  rec_distance = '0;
    logic [TIME_W-1:0]  rec_time = '0;
    logic [SPEED_W-1:0] rec_speed = '0;
    logic               last_record = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               reached;
    logic [TIME_W-1:0]  time_at_target;
    logic [SPEED_W-1:0] speed_at_target;

    // predictor state
    logic [DIST_W-1:0]  tgt_dist = '0;
    logic [DIST_W-1:0]  low_dist = '0;
    logic [TIME_W-1:0]  low_time = '0;
    logic [SPEED_W-1:0] low_speed = '0;
    bit                 run_hit = 1'b0;

    crossing_t expected_results[$];
    stim_row_t directed[$];
    crossing_t want;

    int errors = 0;
    int records = 0;
    int live_records = 0;
    int results_checked = 0;
    int target_writes = 0;
    int stall_cycles = 0;
    int burst_left = 0;

    // receiver pattern state
    int  rx_tick = 0;
    int  rx_mode = 0;
    int  hold_left = 0;
    bit  pressure_done = 1'b0;
    logic pressure_go = 1'b0;

    distance_crossing_interpolator uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .rec_distance(rec_distance), .rec_time(rec_time), .rec_speed(rec_speed),
        .last_record(last_record),
        .out_valid(out_valid), .out_ready(out_ready),
        .reached(reached), .time_at_target(time_at_target),
        .speed_at_target(speed_at_target)
    );

    always #6 clk = ~clk;

    // lo + (hi - lo) * num / gap, nearest with ties away from zero
    function automatic logic [31:0] blend(input logic [31:0] lo, input logic [31:0] hi,
                                          input logic [63:0] num, input logic [63:0] gap);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (hi >= lo) ? 64'(hi) - 64'(lo) : 64'(lo) - 64'(hi);
        q = (mag * num + gap / 2) / gap;
        if (q > mag)
            q = mag;
        return (hi >= lo) ? lo + q[31:0] : lo - q[31:0];
    endfunction

    // advance the crossing search by one record; returns 1 when a result is due
    function automatic bit crossing_step(input logic [DIST_W-1:0] d,
                                         input logic [TIME_W-1:0] t,
                                         input logic [SPEED_W-1:0] s,
                                         input bit last, output crossing_t res);
        logic [63:0] gap;
        logic [63:0] num;
        logic [31:0] sp;
        res = '0;
        if (run_hit)
        begin
            if (last)
            begin
                {low_dist, low_time, low_speed, run_hit} = '0;
            end
            return 1'b0;
        end
        if (d < tgt_dist)
        begin
            low_dist = d;
            low_time = t;
            low_speed = s;
            if (last)
            begin
                {low_dist, low_time, low_speed, run_hit} = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        gap = (d >= low_dist) ? 64'(d) - 64'(low_dist) : 64'd0;
        res.reached = 1'b1;
        if (gap * 2 < (64'd1 << FRAC_BITS_DEFAULT))
        begin
            res.at_time = low_time;
            res.at_speed = low_speed;
        end
        else
        begin
            num = (tgt_dist >= low_dist) ? 64'(tgt_dist) - 64'(low_dist) : 64'd0;
            if (num > gap)
                num = gap;
            res.at_time = blend(low_time, t, num, gap);
            sp = blend({8'd0, low_speed}, {8'd0, s}, num, gap);
            res.at_speed = sp[SPEED_W-1:0];
        end
        if (last)
            {low_dist, low_time, low_speed, run_hit} = '0;
        else
            run_hit = 1'b1;
        return 1'b1;
    endfunction

    task automatic add_row(input bit set_tgt, input logic [31:0] tgt,
                           input logic [31:0] d, input logic [31:0] t, input logic [23:0] s,
                           input bit last, input bit typed, input bit emits,
                           input logic r, input logic [31:0] rt, input logic [23:0] rs);
        stim_row_t row;
        row.set_tgt = set_tgt;
        row.tgt = tgt;
        row.distance = d;
        row.tm = t;
        row.spd = s;
        row.last = last;
        row.typed = typed;
        row.emits = emits;
        row.res = '{r, rt, rs};
        directed = {directed, row};
    endtask

    // drain all pending results, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // apb write of the target register while the block is idle
    task automatic set_target(input logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TARGET_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tgt_dist = value;
        target_writes++;
    endtask

    // offer one record, wait for its transfer and log what it should produce
    task automatic send_record(input logic [31:0] d, input logic [31:0] t,
                               input logic [23:0] s, input bit last,
                               input bit typed, input bit emits, input crossing_t typed_res);
        int gap_len;
        bit due;
        bit was_live;
        crossing_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rec_distance <= d;
        rec_time <= t;
        rec_speed <= s;
        last_record <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        was_live = !run_hit;
        due = crossing_step(d, t, s, last, res);
        records++;
        if (was_live)
            live_records++;
        if (typed)
        begin
            if (emits)
                expected_results = {expected_results, typed_res};
        end
        else if (due)
        begin
            expected_results = {expected_results, res};
        end
    endtask

    // one run of records, mostly sorted around the target, sometimes scrambled
    task automatic random_run();
        int unsigned len;
        int unsigned i;
        bit noise;
        bit last;
        longint unsigned span;
        longint unsigned pos;
        longint unsigned step;
        longint unsigned step_max;
        logic [31:0] d;
        logic [31:0] t;
        logic [23:0] s;
        len = $urandom_range(1, 10);
        noise = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: span = 64'h100;
            1: span = 64'h1_0000;
            2: span = 64'h100_0000;
            default: span = 64'hFFFF_FFFF;
        endcase
        step = {32'd0, $urandom} % (span + 1);
        pos = (step > tgt_dist) ? 64'd0 : 64'(tgt_dist) - step;
        step_max = (2 * span) / len + 1;
        for (i = 0; i < len; i++)
        begin
            if (noise)
                d = $urandom;
            else
                d = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
            t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF) : $urandom;
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12'hFFF)
                                           : $urandom_range(0, 24'hFF_FFFF);
            last = (i == len - 1);
            send_record(d, t, s, last, 1'b0, 1'b0, '0);
            // target moved in the middle of a run
            if (!last && $urandom_range(0, 59) == 0)
                set_target($urandom);
            if ($urandom_range(0, 3) == 0)
                step = $urandom_range(0, 16'h90);
            else
                step = {32'd0, $urandom} % step_max;
            pos += step;
        end
    endtask

    // receiver: own stall pattern plus long hold-offs
    always @(posedge clk)
    begin
        rx_tick++;
        if (pressure_go && !pressure_done)
        begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_HOLD;
        end
        else if (hold_left == 0 && $urandom_range(0, 2999) == 0)
        begin
            hold_left = $urandom_range(50, 300);
        end
        if (rx_tick % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing pending: reached %0b time %h speed %h",
                       reached, time_at_target, speed_at_target);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (reached !== want.reached)
                begin
                    $error("reached expected %0b actual %0b", want.reached, reached);
                    errors++;
                end
                if (time_at_target !== want.at_time)
                begin
                    $error("time_at_target expected %h actual %h",
                           want.at_time, time_at_target);
                    errors++;
                end
                if (speed_at_target !== want.at_speed)
                begin
                    $error("speed_at_target expected %h actual %h",
                           want.at_speed, speed_at_target);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable && pwrite && pready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("distance_crossing_interpolator test failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        // set_tgt tgt         distance      time          speed     last typed emits
        //                                                                  reached time speed
        add_row(1, 32'h100, 32'h80, 32'h10, 24'h20, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'h180, 32'h300, 24'h400, 0, 0, 0, 0, 0, 0);
        // ignored after the hit, then the final record clears the run
        add_row(0, 0, 32'h200, 32'h0, 24'h0, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1, 1, 0, 0, 0, 0);
        // first record exactly at the target, lower record still zero
        add_row(0, 0, 32'h100, 32'h1000, 24'h800, 1, 1, 1, 1, 32'h1000, 24'h800);
        // run ends below the target
        add_row(0, 0, 32'h50, 32'h5, 24'h6, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'h60, 32'hFFFF_FFFF, 24'hFF_FFFF, 1, 1, 1, 0, 0, 0);
        // gap under half a unit keeps the lower values
        add_row(0, 0, 32'hF0, 32'h111, 24'h222, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'h16F, 32'h999, 24'h888, 1, 1, 1, 1, 32'h111, 24'h222);
        // falling values
        add_row(0, 0, 32'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'h200, 32'h0, 24'h0, 1, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'hAA, 32'h1234_5678, 24'hAB_CDEF, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'h155, 32'h0, 24'h10, 1, 0, 0, 0, 0, 0);
        // zero target
        add_row(1, 32'h0, 32'h0, 32'h1234, 24'h5678, 1, 1, 1, 1, 0, 0);
        // largest target
        add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 24'h55_5555, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1, 1, 1,
                1, 32'hAAAA_AAAA, 24'h55_5555);
        add_row(0, 0, 32'h0, 32'h0, 24'h0, 0, 1, 0, 0, 0, 0);
        add_row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1, 1, 1,
                1, 32'hFFFF_FFFF, 24'hFF_FFFF);
        // target lowered mid-run below the lower record distance
        add_row(1, 32'h1000, 32'hF00, 32'h40, 24'h50, 0, 1, 0, 0, 0, 0);
        add_row(1, 32'h800, 32'hC00, 32'h7777, 24'h6666, 1, 1, 1, 1, 32'h40, 24'h50);
        // target lowered mid-run, numerator clamps to zero
        add_row(1, 32'h1000, 32'h800, 32'h100, 24'h200, 0, 1, 0, 0, 0, 0);
        add_row(1, 32'h400, 32'hC00, 32'h900, 24'h700, 1, 1, 1, 1, 32'h100, 24'h200);
        // single-record run short of the target
        add_row(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 24'hAA_AAAA, 1, 1, 1, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
        begin
            if (directed[i].set_tgt)
                set_target(directed[i].tgt);
            send_record(directed[i].distance, directed[i].tm, directed[i].spd,
                        directed[i].last, directed[i].typed, directed[i].emits,
                        directed[i].res);
        end

        // random phases, each with a fresh target
        while (records < directed.size() + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: set_target(32'h0);
                1: set_target(32'hFFFF_FFFF);
                2: set_target($urandom_range(0, 32'h1000));
                default: set_target($urandom);
            endcase
            pressure_go <= 1'b1;
            repeat ($urandom_range(3, 12)) random_run();
        end

        wait_idle();
        $display("%0d records sent (%0d directed, %0d still searching), %0d results checked",
                 records, directed.size(), live_records, results_checked);
        $display("%0d target writes; receiver hold-off of %0d cycles while records kept coming",
                 target_writes, PRESSURE_HOLD);
        if (errors == 0)
            $display("distance_crossing_interpolator test passed");
        else
            $display("distance_crossing_interpolator test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dci_pkg.sv
rtl/core/dci_ctrl.sv
rtl/core/dci_datapath.sv
rtl/core/distance_crossing_interpolator.sv
bench/testbench.sv
